[sv/b4d_pkg.sv]
// Shared types, constants and helper functions of the blocked 4D iterator.
`default_nettype none
package b4d_pkg;

  localparam int CW  = 11;   // coordinate and extent width
  localparam int OW  = 41;   // block-order offset width
  localparam int SDW = 42;   // signed move distance width
  localparam int DVW = 33;   // divisor width (product of up to three extents)
  localparam int MAX_EXTENT = 1024;

  typedef logic [2:0] act_t;
  localparam act_t ACT_REWIND = 3'd0;
  localparam act_t ACT_END    = 3'd1;
  localparam act_t ACT_FWD    = 3'd2;
  localparam act_t ACT_BACK   = 3'd3;
  localparam act_t ACT_MOVE   = 3'd4;
  localparam act_t ACT_SEEK   = 3'd5;

  // Conversion steps from an offset back to coordinates.
  typedef logic [2:0] step_t;
  localparam step_t STEP_TW = 3'd0;   // w tile
  localparam step_t STEP_TZ = 3'd1;   // z tile
  localparam step_t STEP_TY = 3'd2;   // y tile
  localparam step_t STEP_TX = 3'd3;   // x tile
  localparam step_t STEP_IW = 3'd4;   // w inside the tile
  localparam step_t STEP_IZ = 3'd5;   // z inside the tile
  localparam step_t STEP_IY = 3'd6;   // y and x inside the tile

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOT_A, ST_TOT_B, ST_TOT_C, ST_DECIDE, ST_ROUTE,
    ST_DIV_START, ST_DIVIDE, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_TOT_A, OP_TOT_B, OP_TOT_C, OP_DECIDE, OP_DIV_START,
    OP_POST, OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    logic  capture;
    op_t   op;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic need_conv;
    logic div_done;
  } sts_t;

  // Length of the tile that starts at base along an axis of n elements.
  function automatic logic [2:0] tile_len(input logic [CW-1:0] base,
                                          input logic [CW-1:0] n);
    logic [CW-1:0] room;
    room = n - base;
    tile_len = (room >= CW'(4)) ? 3'd4 : room[2:0];
  endfunction

  function automatic logic [CW-1:0] clamp_ext(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) r = CW'(1);
    else if ({21'b0, v} > 32'(MAX_EXTENT)) r = CW'(MAX_EXTENT);
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/blocked_4d_iterator_address_gen_unit.sv]
// Top level of the blocked 4D iterator: controller, datapath and checks.
//
//  Channel | Direction | Handshake            | Word contents
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready  | action, step_distance, seek_offset
//  out     | output    | out_valid / out_ready| cur_x..cur_w, block_offset, at_end,
//          |           |                      | refused
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One word is processed at a time. A rewind, a jump to the end, a refused
// request or a move that lands on offset zero or on the end marker passes
// from acceptance through the total, decide and route states to the output
// register. Any other move or seek converts the offset back to coordinates
// with seven divisions on one shared restoring divider at one quotient bit
// per cycle. Reset is synchronous and active high; it clears the position and
// sets all extents to one. A finished word waits in the output register while
// the next input word is accepted; a stalled output holds only the final load.
`default_nettype none
module blocked_4d_iterator_address_gen_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        action,
  input  wire logic signed [b4d_pkg::SDW-1:0]    step_distance,
  input  wire logic [b4d_pkg::OW-1:0]            seek_offset,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [b4d_pkg::CW-1:0]                 cur_x,
  output logic [b4d_pkg::CW-1:0]                 cur_y,
  output logic [b4d_pkg::CW-1:0]                 cur_z,
  output logic [b4d_pkg::CW-1:0]                 cur_w,
  output logic [b4d_pkg::OW-1:0]                 block_offset,
  output logic                                   at_end,
  output logic                                   refused,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [b4d_pkg::CW-1:0]            cfg_data
);

  b4d_pkg::cmd_t cmd;
  b4d_pkg::sts_t sts;

  // The controller walks each word through total computation, the decision
  // on the target offset and, when needed, the seven conversion divisions.
  b4d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the position together with its block-order offset, so
  // the offset never has to be recomputed from the coordinates.
  b4d_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .step_distance (step_distance),
    .seek_offset   (seek_offset),
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .cur_z         (cur_z),
    .cur_w         (cur_w),
    .block_offset  (block_offset),
    .at_end        (at_end),
    .refused       (refused)
  );

  // The end marker always sits at x, y and z equal to zero.
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_end |-> cur_x == '0 && cur_y == '0 && cur_z == '0)
    else $error("end marker with nonzero x, y or z");

  // At the end marker w equals an extent, which is never zero.
  a_end_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_end |-> cur_w != '0)
    else $error("end marker with zero w");

  // Once a word is taken the block stays busy until it has finished it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in flight");

  // The divider only reports completion while the controller waits on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> !in_ready)
    else $error("divider finished outside a conversion");

endmodule
`default_nettype wire

[sv/b4d_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module b4d_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [b4d_pkg::OW-1:0]    dividend,
  input  wire logic [b4d_pkg::DVW-1:0]   divisor,
  output logic      [b4d_pkg::OW-1:0]    quo,
  output logic      [b4d_pkg::DVW-1:0]   rem,
  output logic                           done
);

  logic [b4d_pkg::DVW-1:0] dsr;
  logic [5:0]              cnt;
  logic                    busy;
  logic [b4d_pkg::DVW:0]   trial;
  logic                    fits;

  assign trial = {rem, quo[b4d_pkg::OW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(b4d_pkg::OW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[b4d_pkg::OW-2:0], fits};
      rem <= fits ? b4d_pkg::DVW'(trial - {1'b0, dsr}) : trial[b4d_pkg::DVW-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/b4d_ctrl.sv]
// Controller state machine that sequences one word through the datapath.
`default_nettype none
module b4d_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire b4d_pkg::sts_t sts,
  output b4d_pkg::cmd_t      cmd
);

  b4d_pkg::state_t state, state_next;
  b4d_pkg::step_t  step, step_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= b4d_pkg::ST_IDLE;
      step      <= b4d_pkg::STEP_TW;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.op         = b4d_pkg::OP_NONE;
    cmd.step       = step;
    unique case (state)
      b4d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = b4d_pkg::ST_TOT_A;
        end
      end
      b4d_pkg::ST_TOT_A: begin
        cmd.op     = b4d_pkg::OP_TOT_A;
        state_next = b4d_pkg::ST_TOT_B;
      end
      b4d_pkg::ST_TOT_B: begin
        cmd.op     = b4d_pkg::OP_TOT_B;
        state_next = b4d_pkg::ST_TOT_C;
      end
      b4d_pkg::ST_TOT_C: begin
        cmd.op     = b4d_pkg::OP_TOT_C;
        state_next = b4d_pkg::ST_DECIDE;
      end
      b4d_pkg::ST_DECIDE: begin
        cmd.op     = b4d_pkg::OP_DECIDE;
        state_next = b4d_pkg::ST_ROUTE;
      end
      b4d_pkg::ST_ROUTE: begin
        step_next  = b4d_pkg::STEP_TW;
        state_next = sts.need_conv ? b4d_pkg::ST_DIV_START : b4d_pkg::ST_FINISH;
      end
      b4d_pkg::ST_DIV_START: begin
        cmd.op     = b4d_pkg::OP_DIV_START;
        state_next = b4d_pkg::ST_DIVIDE;
      end
      b4d_pkg::ST_DIVIDE: begin
        if (sts.div_done) begin
          cmd.op = b4d_pkg::OP_POST;
          if (step == b4d_pkg::STEP_IY) begin
            state_next = b4d_pkg::ST_FINISH;
          end else begin
            step_next  = step + 3'd1;
            state_next = b4d_pkg::ST_DIV_START;
          end
        end
      end
      b4d_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op         = b4d_pkg::OP_LOAD_OUT;
          out_valid_next = 1'b1;
          state_next     = b4d_pkg::ST_IDLE;
        end
      end
      default: state_next = b4d_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/b4d_dp.sv]
// Datapath: extents, position, offset arithmetic and the output register.
`default_nettype none
module b4d_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire b4d_pkg::cmd_t               cmd,
  output b4d_pkg::sts_t                    sts,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [b4d_pkg::CW-1:0]      cfg_data,
  input  wire logic [2:0]                  action,
  input  wire logic signed [b4d_pkg::SDW-1:0] step_distance,
  input  wire logic [b4d_pkg::OW-1:0]      seek_offset,
  output logic [b4d_pkg::CW-1:0]           cur_x,
  output logic [b4d_pkg::CW-1:0]           cur_y,
  output logic [b4d_pkg::CW-1:0]           cur_z,
  output logic [b4d_pkg::CW-1:0]           cur_w,
  output logic [b4d_pkg::OW-1:0]           block_offset,
  output logic                             at_end,
  output logic                             refused
);

  localparam int CW  = b4d_pkg::CW;
  localparam int OW  = b4d_pkg::OW;
  localparam int DVW = b4d_pkg::DVW;

  logic [CW-1:0]  ext_x, ext_y, ext_z, ext_w;
  logic [CW-1:0]  pos_x, pos_y, pos_z, pos_w;
  logic [CW-1:0]  bx, by, bz, bw;
  logic [2:0]     sx, sy, sz, sw;
  logic [OW-1:0]  cur_off, total, seek, p;
  logic [21:0]    nxy;
  logic [DVW-1:0] nxyz;
  logic [43:0]    tot_full;
  b4d_pkg::act_t  act;
  logic signed [b4d_pkg::SDW-1:0] delta;
  logic           refused_r, need_conv;

  logic [OW-1:0]  div_q;
  logic [DVW-1:0] div_r;
  logic           div_done;
  logic [DVW-1:0] dv;
  logic [CW-1:0]  q, qb, qe;
  logic [2:0]     qlen;
  logic [OW-1:0]  prem;
  logic [CW-1:0]  cfg_v;

  logic signed [OW+1:0] sum;
  logic           mv, ref_c;
  logic [OW-1:0]  mtgt;

  assign cfg_v    = b4d_pkg::clamp_ext(cfg_data);
  assign tot_full = 44'(nxyz) * 44'(ext_w);
  assign sts.need_conv = need_conv;
  assign sts.div_done  = div_done;

  // Divisor of each conversion step.
  always_comb begin
    case (cmd.step)
      b4d_pkg::STEP_TW: dv = nxyz;
      b4d_pkg::STEP_TZ: dv = DVW'(nxy) * DVW'(sw);
      b4d_pkg::STEP_TY: dv = DVW'(ext_x) * DVW'(sz) * DVW'(sw);
      b4d_pkg::STEP_TX: dv = DVW'(sy) * DVW'(sz) * DVW'(sw);
      b4d_pkg::STEP_IW: dv = DVW'(sx) * DVW'(sy) * DVW'(sz);
      b4d_pkg::STEP_IZ: dv = DVW'(sx) * DVW'(sy);
      default:          dv = DVW'(sx);
    endcase
  end

  // Tile base, tile length and the remainder left after removing whole tiles.
  always_comb begin
    q  = div_q[CW-1:0];
    qb = {q[CW-1:2], 2'b00};
    case (cmd.step)
      b4d_pkg::STEP_TW: qe = ext_w;
      b4d_pkg::STEP_TZ: qe = ext_z;
      b4d_pkg::STEP_TY: qe = ext_y;
      default:          qe = ext_x;
    endcase
    qlen = b4d_pkg::tile_len(qb, qe);
    prem = OW'(div_r) + (q[0] ? OW'(dv) : '0) + (q[1] ? (OW'(dv) << 1) : '0);
  end

  // Target offset of the requested action.
  always_comb begin
    sum   = $signed({2'b00, cur_off}) + $signed({delta[b4d_pkg::SDW-1], delta});
    mv    = 1'b0;
    ref_c = 1'b0;
    mtgt  = cur_off;
    case (act)
      b4d_pkg::ACT_REWIND: begin
        mv   = 1'b1;
        mtgt = '0;
      end
      b4d_pkg::ACT_END: begin
        mv   = 1'b1;
        mtgt = total;
      end
      b4d_pkg::ACT_FWD: begin
        if (cur_off >= total) ref_c = 1'b1;
        else begin
          mv   = 1'b1;
          mtgt = cur_off + OW'(1);
        end
      end
      b4d_pkg::ACT_BACK: begin
        if (cur_off == '0) ref_c = 1'b1;
        else begin
          mv   = 1'b1;
          mtgt = cur_off - OW'(1);
        end
      end
      b4d_pkg::ACT_MOVE: begin
        if (sum[OW+1] || (sum[OW:0] > {1'b0, total})) ref_c = 1'b1;
        else begin
          mv   = 1'b1;
          mtgt = sum[OW-1:0];
        end
      end
      b4d_pkg::ACT_SEEK: begin
        if (seek > total) ref_c = 1'b1;
        else begin
          mv   = 1'b1;
          mtgt = seek;
        end
      end
      default: ;
    endcase
  end

  b4d_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == b4d_pkg::OP_DIV_START),
    .dividend (p),
    .divisor  (dv),
    .quo      (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  // Architectural state: extents, position and its offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_x     <= CW'(1);
      ext_y     <= CW'(1);
      ext_z     <= CW'(1);
      ext_w     <= CW'(1);
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      pos_w     <= '0;
      cur_off   <= '0;
      need_conv <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        2'd0:    ext_x <= cfg_v;
        2'd1:    ext_y <= cfg_v;
        2'd2:    ext_z <= cfg_v;
        default: ext_w <= cfg_v;
      endcase
      pos_x   <= '0;
      pos_y   <= '0;
      pos_z   <= '0;
      pos_w   <= '0;
      cur_off <= '0;
    end else if (cmd.op == b4d_pkg::OP_DECIDE) begin
      need_conv <= 1'b0;
      if (mv) begin
        cur_off <= mtgt;
        if (mtgt == total) begin
          pos_x <= '0;
          pos_y <= '0;
          pos_z <= '0;
          pos_w <= ext_w;
        end else if (mtgt == '0) begin
          pos_x <= '0;
          pos_y <= '0;
          pos_z <= '0;
          pos_w <= '0;
        end else begin
          need_conv <= 1'b1;
        end
      end
    end else if (cmd.op == b4d_pkg::OP_POST) begin
      case (cmd.step)
        b4d_pkg::STEP_IW: pos_w <= bw + q;
        b4d_pkg::STEP_IZ: pos_z <= bz + q;
        b4d_pkg::STEP_IY: begin
          pos_y <= by + q;
          pos_x <= bx + CW'(div_r);
        end
        default: ;
      endcase
    end
  end

  // Working registers of one word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act   <= action;
      delta <= step_distance;
      seek  <= seek_offset;
    end
    case (cmd.op)
      b4d_pkg::OP_TOT_A: nxy <= 22'(ext_x) * 22'(ext_y);
      b4d_pkg::OP_TOT_B: nxyz <= DVW'(nxy) * DVW'(ext_z);
      b4d_pkg::OP_TOT_C: total <= tot_full[OW-1:0];
      b4d_pkg::OP_DECIDE: begin
        refused_r <= ref_c;
        p         <= mtgt;
      end
      b4d_pkg::OP_POST: begin
        case (cmd.step)
          b4d_pkg::STEP_TW: begin
            bw <= qb;
            sw <= qlen;
            p  <= prem;
          end
          b4d_pkg::STEP_TZ: begin
            bz <= qb;
            sz <= qlen;
            p  <= prem;
          end
          b4d_pkg::STEP_TY: begin
            by <= qb;
            sy <= qlen;
            p  <= prem;
          end
          b4d_pkg::STEP_TX: begin
            bx <= qb;
            sx <= qlen;
            p  <= prem;
          end
          default: p <= OW'(div_r);
        endcase
      end
      b4d_pkg::OP_LOAD_OUT: begin
        cur_x        <= pos_x;
        cur_y        <= pos_y;
        cur_z        <= pos_z;
        cur_w        <= pos_w;
        block_offset <= cur_off;
        at_end       <= pos_w >= ext_w;
        refused      <= refused_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of the blocked 4D iterator with its own block-order position model.
`timescale 1ns / 1ps
module tb_top;

  localparam int CW         = b4d_pkg::CW;
  localparam int OW         = b4d_pkg::OW;
  localparam int SDW        = b4d_pkg::SDW;
  localparam int MAX_EXTENT = b4d_pkg::MAX_EXTENT;

  // Codes the package leaves unnamed: both must leave the position alone.
  localparam b4d_pkg::act_t ACT_NOP6 = 3'd6;
  localparam b4d_pkg::act_t ACT_NOP7 = 3'd7;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_EXT_X = 2'd0;
  localparam logic [1:0] REG_EXT_Y = 2'd1;
  localparam logic [1:0] REG_EXT_Z = 2'd2;
  localparam logic [1:0] REG_EXT_W = 2'd3;

  localparam int WATCHDOG  = 20000;   // cycles with no word moving on either side
  localparam int HOLD_LEN  = 1500;    // long receiver hold-off
  localparam int DRAIN     = 400;     // one slow conversion and some margin
  localparam int PER_PHASE = 158;     // random words per configuration

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = b4d_pkg::ACT_REWIND;
  logic signed [SDW-1:0] step_distance = '0;
  logic [OW-1:0] seek_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CW-1:0] cur_x, cur_y, cur_z, cur_w;
  logic [OW-1:0] block_offset;
  logic at_end, refused;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_EXT_X;
  logic [CW-1:0] cfg_data = '0;

  blocked_4d_iterator_address_gen_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .step_distance(step_distance), .seek_offset(seek_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z), .cur_w(cur_w),
    .block_offset(block_offset), .at_end(at_end), .refused(refused),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One reported position, as the output word carries it.
  typedef struct {
    logic [CW-1:0] x, y, z, w;
    logic [OW-1:0] off;
    logic          at_end;
    logic          refused;
  } posn_t;

  // One row of the directed table. When known is set the expected word is
  // typed in the row; otherwise the position model supplies it.
  typedef struct {
    b4d_pkg::act_t         act;
    logic signed [SDW-1:0] delta;
    logic [OW-1:0]         seek;
    bit                    known;
    posn_t                 want;
  } row_t;

  posn_t want_q[$];
  int    errors = 0;
  int    snd_idle = 17;
  int    rcv_idle = 62;
  bit    hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // Position model: extents and the current position, all kept at 64 bits.
  // ---------------------------------------------------------------------
  logic [63:0] ext [4];
  logic [63:0] px, py, pz, pw;

  function automatic logic [63:0] tile_span(input logic [63:0] b, input logic [63:0] n);
    logic [63:0] top;
    top = b + 4;
    if (top > n) top = n;
    return top - b;
  endfunction

  function automatic logic [63:0] grid_total();
    return ext[0] * ext[1] * ext[2] * ext[3];
  endfunction

  // Rank of the current position in block order.
  function automatic logic [63:0] block_rank();
    logic [63:0] bw, bz, by, bx, sw, sz, sy, sx, p;
    if (pw >= ext[3]) return grid_total();
    bw = pw & ~64'd3; sw = tile_span(bw, ext[3]);
    bz = pz & ~64'd3; sz = tile_span(bz, ext[2]);
    by = py & ~64'd3; sy = tile_span(by, ext[1]);
    bx = px & ~64'd3; sx = tile_span(bx, ext[0]);
    p = bw * ext[0] * ext[1] * ext[2];
    p += bz * ext[0] * ext[1] * sw;
    p += by * ext[0] * sz * sw;
    p += bx * sy * sz * sw;
    p += (pw - bw) * sx * sy * sz;
    p += (pz - bz) * sx * sy;
    p += (py - by) * sx;
    p += px - bx;
    return p;
  endfunction

  // Moves the position to block-order rank p, which lies in 0..total.
  task automatic land_at(input logic [63:0] p);
    logic [63:0] bw, bz, by, bx, sw, sz, sy, sx, q;
    if (p >= grid_total()) begin
      px = 0; py = 0; pz = 0; pw = ext[3];
      return;
    end
    bw = (p / (ext[0] * ext[1] * ext[2])) & ~64'd3; sw = tile_span(bw, ext[3]);
    p -= bw * ext[0] * ext[1] * ext[2];
    bz = (p / (ext[0] * ext[1] * sw)) & ~64'd3; sz = tile_span(bz, ext[2]);
    p -= bz * ext[0] * ext[1] * sw;
    by = (p / (ext[0] * sz * sw)) & ~64'd3; sy = tile_span(by, ext[1]);
    p -= by * ext[0] * sz * sw;
    bx = (p / (sy * sz * sw)) & ~64'd3; sx = tile_span(bx, ext[0]);
    p -= bx * sy * sz * sw;
    q = p / (sx * sy * sz); pw = bw + q; p -= q * sx * sy * sz;
    q = p / (sx * sy);      pz = bz + q; p -= q * sx * sy;
    q = p / sx;             py = by + q; p -= q * sx;
    px = bx + p;
  endtask

  // Applies one word to the model and returns the word the block must report.
  task automatic iter_next(input b4d_pkg::act_t a, input logic signed [SDW-1:0] d,
                           input logic [OW-1:0] s, output posn_t r);
    logic [63:0] tot, cur;
    longint      target;
    bit          rej;
    tot = grid_total();
    cur = block_rank();
    rej = 1'b0;
    case (a)
      b4d_pkg::ACT_REWIND: begin
        px = 0; py = 0; pz = 0; pw = 0;
      end
      b4d_pkg::ACT_END: land_at(tot);
      b4d_pkg::ACT_FWD: begin
        if (cur >= tot) rej = 1'b1;
        else land_at(cur + 1);
      end
      b4d_pkg::ACT_BACK: begin
        if (cur == 0) rej = 1'b1;
        else land_at(cur - 1);
      end
      b4d_pkg::ACT_MOVE: begin
        target = longint'(cur) + longint'(d);
        if (target < 0 || longint'(tot) < target) rej = 1'b1;
        else land_at(64'(target));
      end
      b4d_pkg::ACT_SEEK: begin
        if (64'(s) > tot) rej = 1'b1;
        else land_at(64'(s));
      end
      default: ;
    endcase
    r.x = px[CW-1:0]; r.y = py[CW-1:0]; r.z = pz[CW-1:0]; r.w = pw[CW-1:0];
    r.off = block_rank();
    r.at_end = (pw >= ext[3]);
    r.refused = rej;
  endtask

  // Register write as seen by the model: clamp the extent and rewind.
  task automatic model_cfg(input logic [1:0] idx, input logic [CW-1:0] v);
    logic [63:0] e;
    e = v;
    if (e == 0) e = 1;
    if (e > MAX_EXTENT) e = MAX_EXTENT;
    ext[idx] = e;
    px = 0; py = 0; pz = 0; pw = 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------
  // Input side. The task returns right after the accepting edge with
  // in_valid still high, so a back-to-back word never lowers and raises it
  // in one step.
  // ---------------------------------------------------------------------
  task automatic send_word(input b4d_pkg::act_t a, input logic signed [SDW-1:0] d,
                           input logic [OW-1:0] s, input bit known, input posn_t typed);
    posn_t p;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid      <= 1'b1;
    action        <= a;
    step_distance <= d;
    seek_offset   <= s;
    do @(posedge clk); while (!in_ready);
    iter_next(a, d, s, p);
    want_q.push_back(known ? typed : p);
  endtask

  // Parks the input, then waits until every expected word has come back.
  task automatic drain_out();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes all four extents on consecutive cycles while the block is idle.
  task automatic load_extents(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                              input logic [CW-1:0] vz, input logic [CW-1:0] vw);
    logic [CW-1:0] v [4];
    v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      model_cfg(2'(i), v[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random word. Most words are steps, in-range seeks and moves so that
  // the conversion reaches deep into the grid; the rest hit the edges, use
  // raw random payloads or the unused codes.
  task automatic send_random();
    b4d_pkg::act_t a;
    logic signed [SDW-1:0] d;
    logic [OW-1:0] s;
    logic [63:0] tot;
    int r;
    posn_t none;
    none = '{default: '0};
    tot = grid_total();
    d = SDW'(rnd64());
    s = OW'(rnd64());
    r = $urandom_range(99);
    if (r < 28) a = b4d_pkg::ACT_FWD;
    else if (r < 50) a = b4d_pkg::ACT_BACK;
    else if (r < 66) begin
      a = b4d_pkg::ACT_SEEK;
      s = OW'(rnd64() % (tot + 1));
    end else if (r < 74) begin
      a = b4d_pkg::ACT_MOVE;
      d = SDW'(longint'($urandom_range(64)) - 32);
    end else if (r < 82) begin
      a = b4d_pkg::ACT_MOVE;
      d = SDW'(longint'(rnd64() % (tot + 1)) - longint'(block_rank()));
    end else if (r < 86) a = b4d_pkg::ACT_REWIND;
    else if (r < 90) a = b4d_pkg::ACT_END;
    else if (r < 93) begin
      a = b4d_pkg::ACT_SEEK;
      s = OW'(tot + 1 + $urandom_range(3));
    end else if (r < 97) begin
      a = ($urandom_range(1) != 0) ? b4d_pkg::ACT_MOVE : b4d_pkg::ACT_SEEK;
    end else a = ($urandom_range(1) != 0) ? ACT_NOP6 : ACT_NOP7;
    send_word(a, d, s, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Every accepted output word is compared with the oldest expectation.
  always @(posedge clk) begin
    posn_t e;
    if (!rst && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        e = want_q.pop_front();
        if (cur_x !== e.x) begin
          $error("cur_x expected %0d got %0d", e.x, cur_x); errors++;
        end
        if (cur_y !== e.y) begin
          $error("cur_y expected %0d got %0d", e.y, cur_y); errors++;
        end
        if (cur_z !== e.z) begin
          $error("cur_z expected %0d got %0d", e.z, cur_z); errors++;
        end
        if (cur_w !== e.w) begin
          $error("cur_w expected %0d got %0d", e.w, cur_w); errors++;
        end
        if (block_offset !== e.off) begin
          $error("block_offset expected %0d got %0d", e.off, block_offset); errors++;
        end
        if (at_end !== e.at_end) begin
          $error("at_end expected %0d got %0d", e.at_end, at_end); errors++;
        end
        if (refused !== e.refused) begin
          $error("refused expected %0d got %0d", e.refused, refused); errors++;
        end
      end
    end
  end

  // The watchdog restarts whenever a word moves on either side.
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("blocked_4d_iterator_address_gen_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    row_t  rows [$];
    row_t  rw;
    posn_t org, fin;
    logic [CW-1:0] cfgs [6][4];

    ext[0] = 1; ext[1] = 1; ext[2] = 1; ext[3] = 1;
    px = 0; py = 0; pz = 0; pw = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With all extents at one the grid holds one element, so the origin and
    // the end marker are the only positions and each row can be read off.
    org = '{x: 0, y: 0, z: 0, w: 0, off: 0, at_end: 0, refused: 0};
    fin = '{x: 0, y: 0, z: 0, w: 1, off: 1, at_end: 1, refused: 0};
    rw = '{act: b4d_pkg::ACT_REWIND, delta: '0, seek: '0, known: 1, want: org};
    rows.push_back(rw);
    rw.act = b4d_pkg::ACT_END; rw.want = fin; rows.push_back(rw);
    // Stepping past the end is refused and the end marker is kept.
    rw.act = b4d_pkg::ACT_FWD; rw.want = fin; rw.want.refused = 1; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_BACK; rw.want = org; rows.push_back(rw);
    // Stepping back from offset zero is refused too.
    rw.act = b4d_pkg::ACT_BACK; rw.want = org; rw.want.refused = 1; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_MOVE; rw.delta = 1; rw.want = fin; rows.push_back(rw);
    // Largest and smallest distances leave the range either way.
    rw.delta = {1'b0, {(SDW-1){1'b1}}}; rw.want = fin; rw.want.refused = 1;
    rows.push_back(rw);
    rw.delta = {1'b1, {(SDW-1){1'b0}}}; rows.push_back(rw);
    rw.delta = -1; rw.want = org; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_SEEK; rw.delta = '0; rw.seek = '1; rw.want = org;
    rw.want.refused = 1;
    rows.push_back(rw);
    // A seek to exactly the total lands on the end marker.
    rw.seek = 1; rw.want = fin; rows.push_back(rw);
    rw.seek = 0; rw.want = org; rows.push_back(rw);
    // Unused codes report the current position and are not refused.
    rw.act = ACT_NOP6; rw.seek = '1; rw.delta = '1; rw.want = org; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_END; rw.want = fin; rows.push_back(rw);
    rw.act = ACT_NOP7; rw.want = fin; rows.push_back(rw);
    rw.known = 0; rw.act = b4d_pkg::ACT_SEEK; rw.seek = 2; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_MOVE; rw.delta = 0; rows.push_back(rw);
    rw.act = b4d_pkg::ACT_FWD; rows.push_back(rw);

    foreach (rows[i]) send_word(rows[i].act, rows[i].delta, rows[i].seek,
                                rows[i].known, rows[i].want);
    drain_out();

    // Extent sets: the largest grid, an odd small one, zero and an oversized
    // value that must clamp, two random sets and a long thin grid.
    cfgs[0] = '{11'd1024, 11'd1024, 11'd1024, 11'd1024};
    cfgs[1] = '{11'd5, 11'd3, 11'd7, 11'd2};
    cfgs[2] = '{11'd0, 11'd2047, 11'd1, 11'd6};
    cfgs[3] = '{CW'($urandom_range(1, 9)), CW'($urandom_range(1, 9)),
                CW'($urandom_range(1, 9)), CW'($urandom_range(1, 9))};
    cfgs[4] = '{11'd1, 11'd1, 11'd1, 11'd1024};
    cfgs[5] = '{CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};

    for (int ph = 0; ph < 6; ph++) begin
      // Receiver slow first, then the sender slow, then no idling at all.
      if (ph < 2) begin
        snd_idle = 17; rcv_idle = 62;
      end else if (ph < 4) begin
        snd_idle = 62; rcv_idle = 17;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      load_extents(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      // Stall the output for a long stretch while words keep coming, so the
      // block fills up and holds its input.
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PER_PHASE; n++) send_random();
      drain_out();
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) begin
      $display("blocked_4d_iterator_address_gen_unit: match");
    end else begin
      $display("blocked_4d_iterator_address_gen_unit: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/b4d_pkg.sv
sv/b4d_div.sv
sv/b4d_ctrl.sv
sv/b4d_dp.sv
sv/blocked_4d_iterator_address_gen_unit.sv
dv/tb_top.sv
